// ===== hw/rtl/irft_pkg.sv =====
// Shared types, constants and frame-building functions for the frame transmitter.
`default_nettype none

package irft_pkg;

    // Sizes
    localparam int FRAME_STORE_BYTES = 16;
    localparam int TIMER_BITS        = 20;
    localparam int FRAME_BITS        = FRAME_STORE_BYTES * 8;
    localparam int FIDX_W            = $clog2(FRAME_BITS);
    localparam int QUEUE_DEPTH       = 2;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int SEG_W      = 12;
    localparam int RST_W      = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT      = 3'd0,
        CFG_LONG       = 3'd1,
        CFG_START_HIGH = 3'd2,
        CFG_RESET_HIGH = 3'd3,
        CFG_RESET_LOW  = 3'd4
    } cfg_idx_t;

    localparam logic [SEG_W-1:0] SHORT_RESET      = 12'd208;
    localparam logic [SEG_W-1:0] LONG_RESET       = 12'd1875;
    localparam logic [SEG_W-1:0] START_HIGH_RESET = 12'd900;
    localparam logic [RST_W-1:0] RESET_HIGH_RESET = 20'd325000;
    localparam logic [RST_W-1:0] RESET_LOW_RESET  = 20'd65000;

    // Action codes on the command channel
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_ZONE = 2'd1;
    localparam logic [1:0] ACT_PROG = 2'd2;

    // Argument limits
    localparam logic [5:0] ZONE_MIN    = 6'd1;
    localparam logic [5:0] ZONE_MAX    = 6'd48;
    localparam logic [7:0] MINUTES_MAX = 8'd240;
    localparam logic [2:0] PROG_MIN    = 3'd1;
    localparam logic [2:0] PROG_MAX    = 3'd4;
    localparam logic [5:0] ZONE_GROUP_SPLIT = 6'd12;

    // Frame layout
    localparam logic [6:0] ZONE_FRAME_BITS = 7'd120;
    localparam logic [6:0] PROG_FRAME_BITS = 7'd56;
    localparam logic [0:119] ZONE_BASE =
        120'hff_000000_10_0000_04_0000_01_00_01_b8_3f;
    localparam logic [0:55] PROG_BASE = 56'hff_40_03_96_09_bd_7f;
    localparam logic [7:0] ZONE_OFS_A = 8'h17;
    localparam logic [7:0] ZONE_OFS_B = 8'h23;
    localparam logic [7:0] ZONE_OFS_C = 8'h2f;

    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    typedef logic [0:FRAME_BITS-1] frame_t;

    // Operation handed from the front end to the transmitter
    typedef enum logic [1:0] {
        OP_TICK,
        OP_ZONE,
        OP_PROG,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] zone;
        logic [7:0] minutes;
        logic [2:0] prog;
        logic       warn;
    } cmd_t;

    // Queue write and read sides
    typedef struct packed {
        logic push;
        cmd_t entry;
    } q_wr_t;

    typedef struct packed {
        logic valid;
        cmd_t entry;
    } q_rd_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RESET_HI,
        PH_RESET_LO,
        PH_START_HI,
        PH_START_LO,
        PH_BIT_HI,
        PH_BIT_LO
    } phase_t;

    // Write a field LSB first at increasing frame positions
    function automatic frame_t put_field(frame_t f, int pos, logic [6:0] val, int len);
        frame_t r;
        r = f;
        for (int j = 0; j < 7; j++) begin
            if (j < len) begin
                r[pos + j] = val[j];
            end
        end
        return r;
    endfunction

    function automatic frame_t build_zone(logic [5:0] zone, logic [7:0] minutes);
        frame_t     f;
        logic [7:0] za;
        logic [7:0] zb;
        logic [7:0] zc;
        logic [5:0] zm1;
        logic [6:0] grp;
        logic [6:0] lo;
        logic [6:0] hi;
        f   = '0;
        f[0:119] = ZONE_BASE;
        za  = 8'(zone) + ZONE_OFS_A;
        zb  = 8'(zone) + ZONE_OFS_B;
        zc  = 8'(zone) + ZONE_OFS_C;
        zm1 = zone - 6'd1;
        grp = (zone > ZONE_GROUP_SPLIT) ? 7'd1 : 7'd2;
        lo  = {3'b000, minutes[3:0]};
        hi  = {3'b000, minutes[7:4]};
        f = put_field(f, 9, grp, 2);
        f = put_field(f, 23, za[6:0], 7);
        f = put_field(f, 36, za[6:0], 7);
        f = put_field(f, 49, zb[6:0], 7);
        f = put_field(f, 62, zb[6:0], 7);
        f = put_field(f, 75, zc[6:0], 7);
        f = put_field(f, 88, zc[6:0], 7);
        f = put_field(f, 31, lo, 4);
        f = put_field(f, 44, hi, 4);
        f = put_field(f, 57, lo, 4);
        f = put_field(f, 70, hi, 4);
        f = put_field(f, 83, lo, 4);
        f = put_field(f, 96, hi, 4);
        f = put_field(f, 109, {3'b000, zm1[3:0]}, 4);
        return f;
    endfunction

    function automatic frame_t build_program(logic [2:0] num);
        frame_t     f;
        logic [2:0] nm1;
        f   = '0;
        f[0:55] = PROG_BASE;
        nm1 = num - 3'd1;
        f = put_field(f, 31, {5'b00000, nm1[1:0]}, 2);
        return f;
    endfunction

    // Frame bit, then the appended one, then zeros (stop bit)
    function automatic logic bit_at(frame_t f, logic [6:0] count, logic append,
                                    logic [6:0] idx);
        if (idx < count) begin
            return f[FIDX_W'(idx)];
        end
        else if (append && (idx == count)) begin
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Clamp a segment length to the timer range
    function automatic logic [TIMER_BITS-1:0] sat_len(logic [RST_W-1:0] v);
        if (33'(v) > TIMER_MAX) begin
            return '1;
        end
        return TIMER_BITS'(v);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/irft_if.sv =====
// Valid/ready channel interfaces for commands and line status results.
`default_nettype none

interface irft_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [5:0] zone;
    logic [7:0] minutes;
    logic [2:0] program_req;

    modport source (output valid, action, zone, minutes, program_req, input ready);
    modport sink   (input valid, action, zone, minutes, program_req, output ready);
endinterface

interface irft_res_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic arg_warning;
    logic cmd_ignored;

    modport source (output valid, line_level, busy_res, frame_done, arg_warning,
                    cmd_ignored, input ready);
    modport sink   (input valid, line_level, busy_res, frame_done, arg_warning,
                    cmd_ignored, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/irrigation_remote_frame_transmitter.sv =====
// A command or tick transfer enters the queue; the transmitter then registers
// its result. Throughput: one item per cycle while results are taken, through
// a two-entry queue and a registered result stage; one queued item per cycle.
// Reset (rst_n low, asynchronous): line low, idle, queue empty, timing
// registers back to their defaults; the frame store is left as it is.
`default_nettype none

module irrigation_remote_frame_transmitter (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    irft_cmd_if.sink                             cmd,
    irft_res_if.source                           result,
    input  wire logic                            cfg_we,
    input  wire logic [irft_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [irft_pkg::CFG_DATA_W-1:0] cfg_data
);

    irft_pkg::q_wr_t q_wr;
    irft_pkg::q_rd_t q_rd;
    logic            q_full;
    logic            pop;

    irft_front u_front (
        .cmd    (cmd),
        .q_full (q_full),
        .q_wr   (q_wr)
    );

    irft_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_rd   (q_rd),
        .pop    (pop)
    );

    irft_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd      (q_rd),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/irft_front.sv =====
// Front end: accepts command channel transfers and classifies them into operations.
`default_nettype none

module irft_front (
    irft_cmd_if.sink          cmd,
    input  wire logic         q_full,
    output irft_pkg::q_wr_t   q_wr
);

    irft_pkg::cmd_t entry;

    // Decode the action and check the arguments
    always_comb
    begin
        entry         = '0;
        entry.zone    = cmd.zone;
        entry.minutes = cmd.minutes;
        entry.prog    = cmd.program_req;
        unique case (cmd.action)
            irft_pkg::ACT_TICK:
            begin
                entry.op = irft_pkg::OP_TICK;
            end
            irft_pkg::ACT_ZONE:
            begin
                entry.op   = irft_pkg::OP_ZONE;
                entry.warn = (cmd.zone < irft_pkg::ZONE_MIN) ||
                             (cmd.zone > irft_pkg::ZONE_MAX) ||
                             (cmd.minutes > irft_pkg::MINUTES_MAX);
            end
            irft_pkg::ACT_PROG:
            begin
                entry.op   = irft_pkg::OP_PROG;
                entry.warn = (cmd.program_req < irft_pkg::PROG_MIN) ||
                             (cmd.program_req > irft_pkg::PROG_MAX);
            end
            default:
            begin
                entry.op = irft_pkg::OP_NONE;
            end
        endcase
    end

    // Take a transfer whenever the queue has room
    assign cmd.ready   = !q_full;
    assign q_wr.push   = cmd.valid && !q_full;
    assign q_wr.entry  = entry;

endmodule

`default_nettype wire

// ===== hw/rtl/irft_queue.sv =====
// Short queue between the front end and the transmitter.
`default_nettype none

module irft_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire irft_pkg::q_wr_t    q_wr,
    output logic                    q_full,
    output irft_pkg::q_rd_t         q_rd,
    input  wire logic               pop
);

    irft_pkg::cmd_t                      mem_reg [irft_pkg::QUEUE_DEPTH];
    logic [irft_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [irft_pkg::QPTR_W-1:0]         wr_ptr_next;
    logic [irft_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [irft_pkg::QPTR_W-1:0]         rd_ptr_next;
    logic [irft_pkg::QCNT_W-1:0]         count_reg;
    logic [irft_pkg::QCNT_W-1:0]         count_next;
    logic                                do_pop;

    assign q_full     = (count_reg == irft_pkg::QCNT_W'(irft_pkg::QUEUE_DEPTH));
    assign q_rd.valid = (count_reg != '0);
    assign q_rd.entry = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && q_rd.valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == irft_pkg::QPTR_W'(irft_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == irft_pkg::QPTR_W'(irft_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (q_wr.push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!q_wr.push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entry storage
    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            mem_reg[wr_ptr_reg] <= q_wr.entry;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/irft_back.sv =====
// Transmitter: executes queued operations, times line segments and registers results.
`default_nettype none

module irft_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire irft_pkg::q_rd_t                 q_rd,
    output logic                                 pop,
    input  wire logic                            cfg_we,
    input  wire logic [irft_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [irft_pkg::CFG_DATA_W-1:0] cfg_data,
    irft_res_if.source                           result
);

    // Timing registers
    logic [irft_pkg::SEG_W-1:0] short_reg;
    logic [irft_pkg::SEG_W-1:0] long_reg;
    logic [irft_pkg::SEG_W-1:0] start_high_reg;
    logic [irft_pkg::RST_W-1:0] reset_high_reg;
    logic [irft_pkg::RST_W-1:0] reset_low_reg;

    // Transmit state
    irft_pkg::phase_t              phase_reg;
    irft_pkg::phase_t              phase_next;
    logic                          line_reg;
    logic                          line_next;
    logic [irft_pkg::TIMER_BITS-1:0] timer_reg;
    logic [irft_pkg::TIMER_BITS-1:0] timer_next;
    logic [6:0]                    bit_idx_reg;
    logic [6:0]                    bit_idx_next;
    logic [6:0]                    count_reg;
    logic [6:0]                    count_next;
    logic                          append_reg;
    logic                          append_next;
    irft_pkg::frame_t              frame_reg;
    irft_pkg::frame_t              frame_next;

    // Result register
    logic out_valid_reg;
    logic out_valid_next;
    logic line_out_reg;
    logic line_out_next;
    logic busy_reg;
    logic busy_next;
    logic done_reg;
    logic done_next;
    logic warn_reg;
    logic warn_next;
    logic ign_reg;
    logic ign_next;

    logic       fire;
    logic [6:0] sel_idx;
    logic [6:0] idx_inc;
    logic [7:0] total;
    logic       cur_bit;

    assign fire = q_rd.valid && (!out_valid_reg || result.ready);
    assign pop  = fire;

    // Pick the frame bit that the current transition needs
    assign idx_inc = bit_idx_reg + 7'd1;
    assign sel_idx = (phase_reg == irft_pkg::PH_BIT_LO)   ? idx_inc :
                     (phase_reg == irft_pkg::PH_START_LO) ? 7'd0 : bit_idx_reg;
    assign cur_bit = irft_pkg::bit_at(frame_reg, count_reg, append_reg, sel_idx);
    assign total   = 8'(count_reg) + 8'(append_reg) + 8'd1;

    // Next state and result
    always_comb
    begin
        phase_next     = phase_reg;
        line_next      = line_reg;
        timer_next     = timer_reg;
        bit_idx_next   = bit_idx_reg;
        count_next     = count_reg;
        append_next    = append_reg;
        frame_next     = frame_reg;
        out_valid_next = out_valid_reg && !result.ready;
        line_out_next  = line_out_reg;
        busy_next      = busy_reg;
        done_next      = done_reg;
        warn_next      = warn_reg;
        ign_next       = ign_reg;

        if (fire)
        begin
            done_next = 1'b0;
            warn_next = 1'b0;
            ign_next  = 1'b0;
            unique case (q_rd.entry.op)
                irft_pkg::OP_TICK:
                begin
                    if (phase_reg != irft_pkg::PH_IDLE)
                    begin
                        if (timer_reg > irft_pkg::TIMER_BITS'(1))
                        begin
                            timer_next = timer_reg - 1'b1;
                        end
                        else
                        begin
                            unique case (phase_reg)
                                irft_pkg::PH_RESET_HI:
                                begin
                                    phase_next = irft_pkg::PH_RESET_LO;
                                    line_next  = 1'b0;
                                    timer_next = irft_pkg::sat_len(reset_low_reg);
                                end
                                irft_pkg::PH_RESET_LO:
                                begin
                                    phase_next = irft_pkg::PH_START_HI;
                                    line_next  = 1'b1;
                                    timer_next = irft_pkg::sat_len(
                                        irft_pkg::RST_W'(start_high_reg));
                                end
                                irft_pkg::PH_START_HI:
                                begin
                                    phase_next = irft_pkg::PH_START_LO;
                                    line_next  = 1'b0;
                                    timer_next = irft_pkg::sat_len(
                                        irft_pkg::RST_W'(short_reg));
                                end
                                irft_pkg::PH_START_LO:
                                begin
                                    bit_idx_next = 7'd0;
                                    phase_next   = irft_pkg::PH_BIT_HI;
                                    line_next    = 1'b1;
                                    timer_next   = irft_pkg::sat_len(irft_pkg::RST_W'(
                                        cur_bit ? long_reg : short_reg));
                                end
                                irft_pkg::PH_BIT_HI:
                                begin
                                    phase_next = irft_pkg::PH_BIT_LO;
                                    line_next  = 1'b0;
                                    timer_next = irft_pkg::sat_len(irft_pkg::RST_W'(
                                        cur_bit ? short_reg : long_reg));
                                end
                                irft_pkg::PH_BIT_LO:
                                begin
                                    if ({1'b0, idx_inc} >= total)
                                    begin
                                        phase_next   = irft_pkg::PH_IDLE;
                                        line_next    = 1'b0;
                                        timer_next   = '0;
                                        bit_idx_next = 7'd0;
                                        done_next    = 1'b1;
                                    end
                                    else
                                    begin
                                        bit_idx_next = idx_inc;
                                        phase_next   = irft_pkg::PH_BIT_HI;
                                        line_next    = 1'b1;
                                        timer_next   = irft_pkg::sat_len(irft_pkg::RST_W'(
                                            cur_bit ? long_reg : short_reg));
                                    end
                                end
                                default:
                                begin
                                    phase_next = irft_pkg::PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
                irft_pkg::OP_ZONE, irft_pkg::OP_PROG:
                begin
                    if (phase_reg != irft_pkg::PH_IDLE)
                    begin
                        ign_next = 1'b1;
                    end
                    else
                    begin
                        warn_next = q_rd.entry.warn;
                        if (q_rd.entry.op == irft_pkg::OP_ZONE)
                        begin
                            frame_next  = irft_pkg::build_zone(q_rd.entry.zone,
                                                               q_rd.entry.minutes);
                            count_next  = irft_pkg::ZONE_FRAME_BITS;
                            append_next = 1'b1;
                        end
                        else
                        begin
                            frame_next  = irft_pkg::build_program(q_rd.entry.prog);
                            count_next  = irft_pkg::PROG_FRAME_BITS;
                            append_next = 1'b0;
                        end
                        bit_idx_next = 7'd0;
                        phase_next   = irft_pkg::PH_RESET_HI;
                        line_next    = 1'b1;
                        timer_next   = irft_pkg::sat_len(reset_high_reg);
                    end
                end
                default:
                begin
                end
            endcase
            out_valid_next = 1'b1;
            line_out_next  = line_next;
            busy_next      = (phase_next != irft_pkg::PH_IDLE);
        end
    end

    // Control and timing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= irft_pkg::PH_IDLE;
            line_reg       <= 1'b0;
            timer_reg      <= '0;
            bit_idx_reg    <= '0;
            count_reg      <= '0;
            append_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            short_reg      <= irft_pkg::SHORT_RESET;
            long_reg       <= irft_pkg::LONG_RESET;
            start_high_reg <= irft_pkg::START_HIGH_RESET;
            reset_high_reg <= irft_pkg::RESET_HIGH_RESET;
            reset_low_reg  <= irft_pkg::RESET_LOW_RESET;
        end
        else
        begin
            phase_reg     <= phase_next;
            line_reg      <= line_next;
            timer_reg     <= timer_next;
            bit_idx_reg   <= bit_idx_next;
            count_reg     <= count_next;
            append_reg    <= append_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (irft_pkg::cfg_idx_t'(cfg_index))
                    irft_pkg::CFG_SHORT:      short_reg      <= cfg_data[irft_pkg::SEG_W-1:0];
                    irft_pkg::CFG_LONG:       long_reg       <= cfg_data[irft_pkg::SEG_W-1:0];
                    irft_pkg::CFG_START_HIGH: start_high_reg <= cfg_data[irft_pkg::SEG_W-1:0];
                    irft_pkg::CFG_RESET_HIGH: reset_high_reg <= cfg_data[irft_pkg::RST_W-1:0];
                    irft_pkg::CFG_RESET_LOW:  reset_low_reg  <= cfg_data[irft_pkg::RST_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Frame store and result payload
    always_ff @(posedge clk)
    begin
        frame_reg    <= frame_next;
        line_out_reg <= line_out_next;
        busy_reg     <= busy_next;
        done_reg     <= done_next;
        warn_reg     <= warn_next;
        ign_reg      <= ign_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.line_level  = line_out_reg;
    assign result.busy_res    = busy_reg;
    assign result.frame_done  = done_reg;
    assign result.arg_warning = warn_reg;
    assign result.cmd_ignored = ign_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/irft_checker.sv =====
// Port-level checks on the frame transmitter and the bind that attaches them.
`default_nettype none

module irft_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire logic line_level,
    input wire logic busy_res,
    input wire logic frame_done,
    input wire logic arg_warning,
    input wire logic cmd_ignored
);

    // No result is offered while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result offered during reset");

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid &&
        $stable({line_level, busy_res, frame_done, arg_warning, cmd_ignored}))
        else $error("stalled result changed");

    // The end of a frame leaves the line low and idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_done |-> !busy_res && !line_level && !cmd_ignored)
        else $error("frame done while line active");

    // A warned command has started its reset pulse
    a_warn_start: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && arg_warning |-> busy_res && line_level && !cmd_ignored && !frame_done)
        else $error("warning without frame start");

    // Commands are only dropped while a frame is on the line
    a_ignore_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && cmd_ignored |-> busy_res)
        else $error("command dropped while idle");

endmodule

bind irrigation_remote_frame_transmitter irft_checker u_irft_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .line_level  (result.line_level),
    .busy_res    (result.busy_res),
    .frame_done  (result.frame_done),
    .arg_warning (result.arg_warning),
    .cmd_ignored (result.cmd_ignored)
);

`default_nettype wire
